FILE: rtl/core/ej2sj_pkg.sv
// shared types, codes and the per-byte conversion step for the euc-jp to shift_jis transcoder
package ej2sj_pkg;

    // escape decoding mode
    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ASCII = 2'd1,
        MODE_X0208 = 2'd2,
        MODE_X0201 = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic [1:0] CFG_DECODE_ESCAPES = 2'd0;
    localparam logic [1:0] CFG_SUBST_FIRST    = 2'd1;
    localparam logic [1:0] CFG_SUBST_SECOND   = 2'd2;

    // source byte codes
    localparam logic [7:0] ESC_BYTE    = 8'h1B;
    localparam logic [7:0] SS2_BYTE    = 8'h8E;
    localparam logic [7:0] SS3_BYTE    = 8'h8F;
    localparam logic [7:0] DOLLAR_BYTE = 8'h24;
    localparam logic [7:0] PAREN_BYTE  = 8'h28;
    localparam logic [7:0] B_BYTE      = 8'h42;
    localparam logic [7:0] AT_BYTE     = 8'h40;
    localparam logic [7:0] J_BYTE      = 8'h4A;
    localparam logic [7:0] I_BYTE      = 8'h49;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_error;
        logic       is_substitute;
    } res_t;

    // control state carried from byte to byte
    typedef struct packed {
        mode_t      mode;
        logic [1:0] skip;
        logic [1:0] held_count;
    } ctl_t;

    // outcome of one pass over the byte at the current position
    typedef struct packed {
        logic [1:0] adv;
        mode_t      mode;
        logic [1:0] skip;
        logic [1:0] nres;
        res_t       r0;
        res_t       r1;
    } iter_t;

    localparam res_t ERROR_RES = '{out_byte: 8'h00, is_error: 1'b1, is_substitute: 1'b0};

    // plain byte result
    function automatic res_t byte_res(input logic [7:0] b);
        res_t r;
        r.out_byte      = b;
        r.is_error      = 1'b0;
        r.is_substitute = 1'b0;
        return r;
    endfunction

    // process the sequence that starts at c_in; adv of zero means wait for more bytes
    function automatic iter_t step_byte(
        input logic [7:0] c_in,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [1:0] rem,
        input mode_t      mode,
        input logic [1:0] skip,
        input logic [7:0] subst_first,
        input logic [7:0] subst_second
    );
        iter_t      o;
        logic [7:0] c;
        logic [7:0] d;
        logic       esc_ok;
        mode_t      esc_mode;
        o.adv  = 2'd0;
        o.mode = mode;
        o.skip = skip;
        o.nres = 2'd0;
        o.r0   = '0;
        o.r1   = '0;
        c = c_in;
        d = b1;
        esc_ok   = 1'b0;
        esc_mode = mode;
        // seven-bit pair in 0208 mode maps onto the euc range
        if (mode == MODE_X0208 && c_in >= 8'h21 && c_in <= 8'h7E
            && b1 >= 8'h21 && b1 <= 8'h7E)
        begin
            c = c_in | 8'h80;
            d = b1 | 8'h80;
        end
        if (skip != 2'd0)
        begin
            o.skip = skip - 2'd1;
            o.adv  = 2'd1;
        end
        else if (mode == MODE_X0201 && c_in >= 8'h21 && c_in <= 8'h5F)
        begin
            o.r0   = byte_res(c_in | 8'h80);
            o.nres = 2'd1;
            o.adv  = 2'd1;
        end
        else if (mode == MODE_X0208 && rem < 2'd2)
        begin
            o.adv = 2'd0;
        end
        else if (c == ESC_BYTE && mode != MODE_OFF)
        begin
            if (rem == 2'd3)
            begin
                if (b1 == DOLLAR_BYTE)
                begin
                    if (b2 == B_BYTE || b2 == AT_BYTE)
                    begin
                        esc_ok   = 1'b1;
                        esc_mode = MODE_X0208;
                    end
                end
                else if (b1 == PAREN_BYTE)
                begin
                    if (b2 == B_BYTE || b2 == J_BYTE)
                    begin
                        esc_ok   = (mode != MODE_ASCII);
                        esc_mode = MODE_ASCII;
                    end
                    else if (b2 == I_BYTE)
                    begin
                        esc_ok   = 1'b1;
                        esc_mode = MODE_X0201;
                    end
                end
                if (esc_ok)
                begin
                    o.mode = esc_mode;
                    o.adv  = 2'd3;
                end
                else
                begin
                    o.r0   = byte_res(ESC_BYTE);
                    o.nres = 2'd1;
                    o.adv  = 2'd1;
                end
            end
        end
        else if (c <= 8'h7F)
        begin
            o.r0   = byte_res(c);
            o.nres = 2'd1;
            o.adv  = 2'd1;
        end
        else if (c >= 8'hA0 && c <= 8'hFE)
        begin
            if (rem >= 2'd2)
            begin
                if (d < 8'hA0 || d == 8'hFF)
                begin
                    o.r0   = ERROR_RES;
                    o.nres = 2'd1;
                    o.adv  = 2'd1;
                end
                else
                begin
                    o.r0 = byte_res(((c - 8'd1) >> 1) + ((c <= 8'hDE) ? 8'h31 : 8'h71));
                    o.r1 = byte_res(d - (c[0] ? ((d < 8'hE0) ? 8'h61 : 8'h60) : 8'h02));
                    o.nres = 2'd2;
                    o.adv  = 2'd2;
                end
            end
        end
        else if (c == SS2_BYTE)
        begin
            if (rem >= 2'd2)
            begin
                o.nres = 2'd1;
                if (d < 8'hA1 || d > 8'hDF)
                begin
                    o.r0  = ERROR_RES;
                    o.adv = 2'd1;
                end
                else
                begin
                    o.r0  = byte_res(d);
                    o.adv = 2'd2;
                end
            end
        end
        else if (c == SS3_BYTE)
        begin
            o.r0.out_byte      = subst_first;
            o.r0.is_error      = 1'b0;
            o.r0.is_substitute = 1'b1;
            o.r1.out_byte      = subst_second;
            o.r1.is_error      = 1'b0;
            o.r1.is_substitute = 1'b1;
            o.nres = 2'd2;
            o.skip = 2'd2;
            o.adv  = 2'd1;
        end
        else
        begin
            o.r0   = ERROR_RES;
            o.nres = 2'd1;
            o.adv  = 2'd1;
        end
        return o;
    endfunction

endpackage

FILE: rtl/core/ej2sj_engine.sv
// combinational conversion of one source byte plus held bytes into up to four result words
module ej2sj_engine (
    input  logic [7:0]        in_byte,
    input  ej2sj_pkg::ctl_t   ctl,
    input  logic [1:0][7:0]   held,
    input  logic [7:0]        subst_first,
    input  logic [7:0]        subst_second,
    output logic [2:0]        nres,
    output ej2sj_pkg::res_t   res [4],
    output ej2sj_pkg::ctl_t   ctl_next,
    output logic [1:0][7:0]   held_next
);

    logic [2:0][7:0] buf_bytes;
    logic [1:0]      n;

    // pick a byte of the working buffer, zero past its end
    function automatic logic [7:0] pick(input logic [2:0][7:0] b, input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = b[0];
            3'd1:    v = b[1];
            3'd2:    v = b[2];
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // held bytes first, then the new byte
    always_comb
    begin
        buf_bytes = '0;
        case (ctl.held_count)
            2'd0:
            begin
                buf_bytes[0] = in_byte;
            end
            2'd1:
            begin
                buf_bytes[0] = held[0];
                buf_bytes[1] = in_byte;
            end
            default:
            begin
                buf_bytes[0] = held[0];
                buf_bytes[1] = held[1];
                buf_bytes[2] = in_byte;
            end
        endcase
        n = (ctl.held_count >= 2'd2) ? 2'd3 : ctl.held_count + 2'd1;
    end

    // up to three sequence steps over the buffer, results packed in order
    always_comb
    begin
        logic [1:0]         pos;
        logic [2:0]         cnt;
        logic               done;
        ej2sj_pkg::mode_t   mode;
        logic [1:0]         skip;
        ej2sj_pkg::iter_t   it;
        ej2sj_pkg::res_t    r;
        pos  = 2'd0;
        cnt  = 3'd0;
        done = 1'b0;
        mode = ctl.mode;
        skip = ctl.skip;
        it   = '0;
        r    = '0;
        for (int j = 0; j < 4; j++)
        begin
            res[j] = '0;
        end
        for (int k = 0; k < 3; k++)
        begin
            if (!done && pos < n)
            begin
                it = ej2sj_pkg::step_byte(pick(buf_bytes, {1'b0, pos}),
                                          pick(buf_bytes, {1'b0, pos} + 3'd1),
                                          pick(buf_bytes, {1'b0, pos} + 3'd2),
                                          n - pos, mode, skip, subst_first, subst_second);
                if (it.adv == 2'd0)
                begin
                    done = 1'b1;
                end
                else
                begin
                    mode = it.mode;
                    skip = it.skip;
                    for (int j = 0; j < 2; j++)
                    begin
                        r = (j == 0) ? it.r0 : it.r1;
                        if (2'(j) < it.nres && cnt < 3'd4)
                        begin
                            res[cnt[1:0]] = r;
                            cnt = cnt + 3'd1;
                        end
                    end
                    pos = pos + it.adv;
                end
            end
        end
        nres                = cnt;
        ctl_next.mode       = mode;
        ctl_next.skip       = skip;
        ctl_next.held_count = n - pos;
        held_next[0]        = pick(buf_bytes, {1'b0, pos});
        held_next[1]        = pick(buf_bytes, {1'b0, pos} + 3'd1);
    end

endmodule

FILE: rtl/core/eucjp_to_shiftjis_transcoder.sv
// top level of the euc-jp (with iso-2022-jp escapes) to shift_jis transcoder
// The block takes one source byte per cycle while in_stall is low and gives one Shift_JIS
// result word per cycle while out_stall is low. A byte goes into an input register, is
// converted together with any held bytes in one pass of logic, and its zero to four result
// words land in a four-entry result register that drains one word a cycle while out_stall
// is low. Bytes that give at most one word sustain one byte per cycle when the output is
// not stalled; a byte that gives several words, such as a kanji pair, a substitute or a
// failed escape, holds the result register until all of them drain. Bytes that only
// complete a pending sequence or are swallowed give no word and never wait on the output.
// last marks the final word of each source byte. Configuration writes are taken at any time
// but belong in idle periods; writing decode_escapes resets the mode and drops held bytes.
module eucjp_to_shiftjis_transcoder (
    input  logic       clk,
    input  logic       rst_n,
    // configuration port
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // source words
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    // result words
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_error,
    output logic       is_substitute,
    output logic       last
);

    logic            decode_escapes_reg;
    logic [7:0]      subst_first_reg;
    logic [7:0]      subst_second_reg;
    ej2sj_pkg::ctl_t ctl_reg;
    ej2sj_pkg::ctl_t ctl_next;
    logic [1:0][7:0] held_reg;
    logic [1:0][7:0] held_next;
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    ej2sj_pkg::res_t blk_res_reg [4];
    logic [2:0]      blk_count_reg;
    logic [1:0]      blk_ptr_reg;
    ej2sj_pkg::res_t eng_res [4];
    logic [2:0]      eng_nres;
    logic            out_fire;
    logic            drain_last;
    logic            blk_free;
    logic            process;
    logic            in_fire;

    // conversion logic
    ej2sj_engine u_engine (
        .in_byte      (in_byte_reg),
        .ctl          (ctl_reg),
        .held         (held_reg),
        .subst_first  (subst_first_reg),
        .subst_second (subst_second_reg),
        .nres         (eng_nres),
        .res          (eng_res),
        .ctl_next     (ctl_next),
        .held_next    (held_next)
    );

    // handshake and flow control
    assign out_valid  = (blk_count_reg != 3'd0);
    assign out_fire   = out_valid && !out_stall;
    assign last       = ({1'b0, blk_ptr_reg} == blk_count_reg - 3'd1);
    assign drain_last = out_fire && last;
    assign blk_free   = !out_valid || drain_last;
    assign process    = in_valid_reg && (blk_free || eng_nres == 3'd0);
    assign in_stall   = in_valid_reg && !process;
    assign in_fire    = in_valid && !in_stall;

    // result word on the output
    assign out_byte      = blk_res_reg[blk_ptr_reg].out_byte;
    assign is_error      = blk_res_reg[blk_ptr_reg].is_error;
    assign is_substitute = blk_res_reg[blk_ptr_reg].is_substitute;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_escapes_reg <= 1'b1;
            subst_first_reg    <= 8'h81;
            subst_second_reg   <= 8'hA0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ej2sj_pkg::CFG_DECODE_ESCAPES: decode_escapes_reg <= cfg_data[0];
                ej2sj_pkg::CFG_SUBST_FIRST:    subst_first_reg    <= cfg_data;
                ej2sj_pkg::CFG_SUBST_SECOND:   subst_second_reg   <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // mode, skip and held count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.mode       <= ej2sj_pkg::MODE_ASCII;
            ctl_reg.skip       <= 2'd0;
            ctl_reg.held_count <= 2'd0;
        end
        else if (cfg_write && cfg_index == ej2sj_pkg::CFG_DECODE_ESCAPES)
        begin
            ctl_reg.mode       <= cfg_data[0] ? ej2sj_pkg::MODE_ASCII : ej2sj_pkg::MODE_OFF;
            ctl_reg.skip       <= 2'd0;
            ctl_reg.held_count <= 2'd0;
        end
        else if (process)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // held bytes, read only below the held count
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            held_reg <= held_next;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_count_reg <= 3'd0;
            blk_ptr_reg   <= 2'd0;
        end
        else if (process && eng_nres != 3'd0)
        begin
            blk_count_reg <= eng_nres;
            blk_ptr_reg   <= 2'd0;
        end
        else if (out_fire)
        begin
            if (last)
            begin
                blk_count_reg <= 3'd0;
                blk_ptr_reg   <= 2'd0;
            end
            else
            begin
                blk_ptr_reg <= blk_ptr_reg + 2'd1;
            end
        end
    end

    // result register words
    always_ff @(posedge clk)
    begin
        if (process && eng_nres != 3'd0)
        begin
            for (int j = 0; j < 4; j++)
            begin
                blk_res_reg[j] <= eng_res[j];
            end
        end
    end

    // read pointer stays inside the loaded words
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, blk_ptr_reg} < blk_count_reg && blk_count_reg <= 3'd4))
        else $error("result pointer outside loaded words");

    // new words only load once the previous ones are gone
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && eng_nres != 3'd0) |-> blk_free)
        else $error("result register overwritten before drained");

    // error words carry a zero byte and no substitute mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_error) |-> (out_byte == 8'h00 && !is_substitute))
        else $error("malformed error word");

    // at most two bytes held and two swallowed
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg.held_count != 2'd3) && (ctl_reg.skip != 2'd3))
        else $error("held or skip count out of range");

endmodule
